// ----- design/emt_pkg.sv -----
`timescale 1ns / 1ps
package emt_pkg;

   // fixed field widths
   localparam int EID_W    = 5;
   localparam int CID_W    = 5;
   localparam int MASK_W   = 32;
   localparam int FUNC_W   = 3;
   localparam int STATUS_W = 2;
   localparam int NCOMP_W  = 6;

   // sizing defaults and fixed bounds
   localparam int DEF_MAX_ENTITIES = 32;
   localparam int MAX_COMPONENTS   = 32;
   localparam int RESULT_LIMIT     = 32;

   localparam logic [NCOMP_W-1:0] NCOMP_RESET = 6'd32;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_KILL   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_HAS    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK            = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL          = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_ENTITY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COMPONENT = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [EID_W-1:0]  ent_id;
      logic [CID_W-1:0]  comp_id;
      logic [MASK_W-1:0] query_mask;
   } req_type;

   typedef struct packed {
      logic [EID_W-1:0]    result_id;
      logic [STATUS_W-1:0] status;
      logic                has_bit;
      logic                found;
      logic                last;
   } rsp_type;

   // command broadcast to the entity cells
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_SHIFT,
      CELL_CREATE,
      CELL_KILL,
      CELL_SET,
      CELL_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [MASK_W-1:0] bit_mask;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

// ----- design/entity_mask_table.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   emt_pkg::req_type
// rsp_      out        rsp_valid/rsp_stall   emt_pkg::rsp_type
// csr_      in         csr_wr_en             csr_wr_data (num_components)
//
// create, kill, add, remove, has and unused codes are answered with one response each.
// a query rotates the whole cell chain once, one entity per cycle past cell 0
// when the output is not stalled, and holds the request side until it ends.
// reset is synchronous and clears the cells, the created count and the free list.
// a stalled response holds the chain in place until it is taken.
module entity_mask_table #(
   parameter int MAX_ENTITIES = emt_pkg::DEF_MAX_ENTITIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  emt_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output emt_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [emt_pkg::NCOMP_W-1:0]   csr_wr_data
);
   import emt_pkg::*;

   localparam int N      = MAX_ENTITIES;
   localparam int IDW    = $clog2(N);
   localparam int CW     = $clog2(N+1);
   localparam int ACELLS = (N < (2**EID_W)) ? N : (2**EID_W);
   localparam int AW     = $clog2(ACELLS);
   localparam int HW     = $clog2(RESULT_LIMIT+1);

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [CW-1:0]      created_ff, created_in;
   logic [NCOMP_W-1:0] ncomp_ff;
   logic [MASK_W-1:0]  qmask_ff, qmask_in;
   logic [CW-1:0]      step_ff, step_in;
   logic [HW-1:0]      hits_ff, hits_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [EID_W-1:0]   pend_id_ff, pend_id_in;

   logic               cell_alive [N];
   logic [MASK_W-1:0]  cell_mask [N];
   logic               addr_alive [ACELLS];
   logic [MASK_W-1:0]  addr_mask [ACELLS];
   logic [N-1:0]       cell_sel;
   cell_cmd_type       cell_cmd;
   logic [IDW-1:0]     target;

   logic               push, pop;
   logic [EID_W-1:0]   free_top_id;
   logic [CW-1:0]      free_count;

   logic               can_load, accept;
   logic [AW-1:0]      eidx;
   logic               eid_bad, cid_bad;
   logic [MASK_W-1:0]  bit_mask;
   logic               walk_hit;

   // entity cells, rotating toward cell 0
   for (genvar i = 0; i < N; i++) begin : g_cell
      localparam int NEXT = (i == N-1) ? 0 : i+1;
      assign cell_sel[i] = (target == IDW'(i));
      emt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cell_cmd),
         .sel        (cell_sel[i]),
         .next_alive (cell_alive[NEXT]),
         .next_mask  (cell_mask[NEXT]),
         .alive      (cell_alive[i]),
         .mask       (cell_mask[i])
      );
   end

   // cells reachable by the request entity id
   for (genvar j = 0; j < ACELLS; j++) begin : g_addr
      assign addr_alive[j] = cell_alive[j];
      assign addr_mask[j]  = cell_mask[j];
   end

   emt_free_stack #(
      .DEPTH (N)
   ) u_free_stack (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (pop),
      .push_id (req_data.ent_id),
      .top_id  (free_top_id),
      .count   (free_count)
   );

   // handshake and request decode
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && can_load);
   assign accept    = req_valid && !req_stall;
   assign eidx      = req_data.ent_id[AW-1:0];
   assign eid_bad   = 32'(req_data.ent_id) >= 32'(N);
   assign cid_bad   = (NCOMP_W'(req_data.comp_id) >= ncomp_ff) ||
                      (32'(req_data.comp_id) >= 32'(MAX_COMPONENTS));
   assign bit_mask  = MASK_W'(1) << req_data.comp_id;
   assign walk_hit  = cell_alive[0] && ((cell_mask[0] & qmask_ff) == qmask_ff) &&
                      (step_ff < created_ff) && (hits_ff < HW'(RESULT_LIMIT));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_QUERY)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (can_load && (step_ff == CW'(N-1))) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath, cell commands and response
   always_comb begin
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_in            = rsp_ff;
      created_in        = created_ff;
      qmask_in          = qmask_ff;
      step_in           = step_ff;
      hits_in           = hits_ff;
      pend_valid_in     = pend_valid_ff;
      pend_id_in        = pend_id_ff;
      cell_cmd.op       = CELL_HOLD;
      cell_cmd.bit_mask = bit_mask;
      target            = '0;
      push              = 1'b0;
      pop               = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               unique case (req_data.func)
                  FUNC_CREATE: begin
                     if (free_count != '0) begin
                        pop         = 1'b1;
                        target      = IDW'(free_top_id);
                        cell_cmd.op = CELL_CREATE;
                     end else if (created_ff < CW'(N)) begin
                        target      = created_ff[IDW-1:0];
                        created_in  = created_ff + CW'(1);
                        cell_cmd.op = CELL_CREATE;
                     end else begin
                        rsp_in.status = STATUS_FULL;
                     end
                     if (cell_cmd.op == CELL_CREATE) begin
                        rsp_in.result_id = EID_W'(target);
                     end
                  end
                  FUNC_KILL: begin
                     if (eid_bad) begin
                        rsp_in.status = STATUS_BAD_ENTITY;
                     end else if (addr_alive[eidx]) begin
                        target      = IDW'(req_data.ent_id);
                        cell_cmd.op = CELL_KILL;
                        push        = free_count < CW'(N);
                     end
                  end
                  FUNC_ADD, FUNC_REMOVE, FUNC_HAS: begin
                     target = IDW'(req_data.ent_id);
                     if (eid_bad) begin
                        rsp_in.status = STATUS_BAD_ENTITY;
                     end else if (cid_bad) begin
                        rsp_in.status = STATUS_BAD_COMPONENT;
                     end else if (req_data.func == FUNC_ADD) begin
                        cell_cmd.op = CELL_SET;
                     end else if (req_data.func == FUNC_REMOVE) begin
                        cell_cmd.op = CELL_CLEAR;
                     end else begin
                        rsp_in.has_bit = addr_mask[eidx][req_data.comp_id];
                     end
                  end
                  FUNC_QUERY: begin
                     rsp_valid_in  = 1'b0;
                     rsp_in        = rsp_ff;
                     qmask_in      = req_data.query_mask;
                     step_in       = '0;
                     hits_in       = '0;
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            // one entity per cycle passes cell 0 unless the output stalls; a hit releases the one before
            if (can_load) begin
               cell_cmd.op = CELL_SHIFT;
               step_in     = step_ff + CW'(1);
               if (walk_hit) begin
                  hits_in       = hits_ff + HW'(1);
                  pend_valid_in = 1'b1;
                  pend_id_in    = EID_W'(step_ff);
                  if (pend_valid_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in           = '0;
                     rsp_in.result_id = pend_id_ff;
                     rsp_in.found     = 1'b1;
                  end
               end
            end
         end
         ST_FINISH: begin
            // final match, or the not-found transaction
            if (can_load) begin
               rsp_valid_in     = 1'b1;
               rsp_in           = '0;
               rsp_in.last      = 1'b1;
               rsp_in.found     = pend_valid_ff;
               rsp_in.result_id = pend_valid_ff ? pend_id_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         created_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         created_ff    <= created_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ncomp_ff <= NCOMP_RESET;
      end else if (csr_wr_en) begin
         ncomp_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      qmask_ff   <= qmask_in;
      step_ff    <= step_in;
      hits_ff    <= hits_in;
      pend_id_ff <= pend_id_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // free list never holds more ids than were ever created
   a_free_le_created: assert property (@(posedge clock) disable iff (reset)
      free_count <= created_ff)
      else $error("free list larger than created count");

   a_created_bound: assert property (@(posedge clock) disable iff (reset)
      created_ff <= CW'(N))
      else $error("created count beyond table size");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken during a query walk");

   a_query_start: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.func == FUNC_QUERY)) |=> ((state_ff == ST_WALK) && !rsp_valid_ff))
      else $error("query did not start a clean walk");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && can_load) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("query ended without a final transaction");

endmodule

// ----- design/emt_cell.sv -----
`timescale 1ns / 1ps
module emt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  emt_pkg::cell_cmd_type       cmd,
   input  logic                        sel,
   input  logic                        next_alive,
   input  logic [emt_pkg::MASK_W-1:0]  next_mask,
   output logic                        alive,
   output logic [emt_pkg::MASK_W-1:0]  mask
);
   import emt_pkg::*;

   logic              alive_ff, alive_in;
   logic [MASK_W-1:0] mask_ff, mask_in;

   // rotate from the neighbor, or apply the addressed update
   always_comb begin
      alive_in = alive_ff;
      mask_in  = mask_ff;
      if (cmd.op == CELL_SHIFT) begin
         alive_in = next_alive;
         mask_in  = next_mask;
      end else if (sel) begin
         unique case (cmd.op)
            CELL_CREATE: begin
               alive_in = 1'b1;
               mask_in  = '0;
            end
            CELL_KILL: begin
               alive_in = 1'b0;
               mask_in  = '0;
            end
            CELL_SET:   mask_in = mask_ff | cmd.bit_mask;
            CELL_CLEAR: mask_in = mask_ff & ~cmd.bit_mask;
            CELL_HOLD, CELL_SHIFT: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff <= 1'b0;
         mask_ff  <= '0;
      end else begin
         alive_ff <= alive_in;
         mask_ff  <= mask_in;
      end
   end

   assign alive = alive_ff;
   assign mask  = mask_ff;

endmodule

// ----- design/emt_free_stack.sv -----
`timescale 1ns / 1ps
module emt_free_stack #(
   parameter int DEPTH = emt_pkg::DEF_MAX_ENTITIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             pop,
   input  logic [emt_pkg::EID_W-1:0]        push_id,
   output logic [emt_pkg::EID_W-1:0]        top_id,
   output logic [$clog2(DEPTH+1)-1:0]       count
);
   import emt_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH+1);

   logic [EID_W-1:0] mem [DEPTH];
   logic [CW-1:0]    count_ff, count_in;
   logic [EID_W-1:0] top_ff;
   logic [AW-1:0]    wr_addr;
   logic [AW-1:0]    rd_addr;

   // push writes the slot above the top; pop prefetches the entry below it
   assign wr_addr = AW'(count_ff);
   assign rd_addr = AW'(count_ff - CW'(2));

   always_comb begin
      count_in = count_ff;
      if (push) begin
         count_in = count_ff + CW'(1);
      end else if (pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_addr] <= push_id;
      end
   end

   // cached copy of the top entry
   always_ff @(posedge clock) begin
      if (push) begin
         top_ff <= push_id;
      end else if (pop) begin
         top_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign top_id = top_ff;
   assign count  = count_ff;

endmodule
